/* rtl/msb_first_bit_packer_macros.svh */
// Assertion helpers used by the packer's top-level RTL.
// Both expect signals named clk and rst_n in the including scope.
`ifndef MSB_FIRST_BIT_PACKER_MACROS_SVH
`define MSB_FIRST_BIT_PACKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSBBP_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MSBBP_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/msbbp_pkg.sv */
`timescale 1ns / 1ps
package msbbp_pkg;

  localparam int BYTE_BITS       = 8;
  localparam int FIELD_LIMIT     = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Command codes on the input word; code 3 carries no meaning.
  typedef enum logic [1:0] {
    CMD_WRITE_BITS = 2'd0,
    CMD_WRITE_WORD = 2'd1,
    CMD_FLUSH      = 2'd2
  } cmd_t;

  // Operation kinds held in the queue between front and back.
  typedef enum logic {
    KIND_APPEND = 1'b0,
    KIND_FLUSH  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] data;
    logic [5:0]  nbits;
  } entry_t;

  // Status of the back end, seen by the top level.
  typedef struct packed {
    logic       busy;
    logic [2:0] left;
  } back_status_t;

endpackage

/* rtl/msbbp_in_if.sv */
`timescale 1ns / 1ps
interface msbbp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] data_value;
  logic [5:0]  field_bits;

  modport source (output valid, output cmd, output data_value, output field_bits,
                  input ready);
  modport sink (input valid, input cmd, input data_value, input field_bits,
                output ready);
endinterface

/* rtl/msbbp_out_if.sv */
`timescale 1ns / 1ps
interface msbbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

/* rtl/msb_first_bit_packer.sv */
`timescale 1ns / 1ps
// Bit packer: appends bit fields most significant bit first to a byte stream.
// The input channel in_ch carries one command word per handshake: write the
// low field_bits bits of data_value (counts above 32 act as 32), write
// data_value as four bytes with the least significant byte first, or flush
// the pending bits as one byte padded with zeros on the right.
// The output channel out_ch carries one packed byte per word, with the first
// written bit in bit 7; last_of_run marks the final byte caused by a command.
// A command that completes no byte produces no output word at all.
// With an idle queue and back end, an accepted command passes from the queue
// into the back end's shift register and then the output register before its
// first byte is on out_ch. A command that completes bytes sends them one byte
// per cycle through the output register while out_ch.ready holds, and short
// fields go at one per cycle unless out_ch stalls.
// A short queue decouples input acceptance from byte emission; in_ch.ready
// falls only when that queue is full.
// When out_ch.ready is low the current byte holds and the back end pauses,
// while the queue keeps taking commands until it fills.
// Synchronous reset clears the pending bits, the queue and the output valid
// flag; no output word is valid after reset.
module msb_first_bit_packer #(
  parameter int QUEUE_DEPTH = msbbp_pkg::QUEUE_DEPTH_DEF
) (
  input logic          clk,
  input logic          rst_n,
  msbbp_in_if.sink     in_ch,
  msbbp_out_if.source  out_ch
);

`include "msb_first_bit_packer_macros.svh"

  msbbp_pkg::entry_t       front_entry;
  logic                    front_valid;
  logic                    front_ready;
  msbbp_pkg::entry_t       q_entry;
  logic                    q_valid;
  logic                    q_ready;
  msbbp_pkg::back_status_t back_stat;

  // The front decodes commands; a flush is resolved later, where the pending
  // count is known.
  msbbp_front u_front (
    .in_ch      (in_ch),
    .entry      (front_entry),
    .push_valid (front_valid),
    .push_ready (front_ready)
  );

  msbbp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_entry (front_entry),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_entry  (q_entry),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready)
  );

  // The back end takes the next command in the cycle its last byte moves
  // into the output register, so bytes of consecutive commands run gap-free.
  msbbp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_entry (q_entry),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .out_ch  (out_ch),
    .status  (back_stat)
  );

  // With no bytes left in the back end, the byte on show is the last of its run.
  `MSBBP_CHK_NOW(a_last_when_drained, out_ch.valid && !back_stat.busy, out_ch.last_of_run, "byte shown with back end drained is not marked last")

  // Bytes waiting and an empty output register: a byte must appear next cycle.
  `MSBBP_CHK_NEXT(a_fill_output, back_stat.busy && !out_ch.valid, out_ch.valid, "output register not refilled while bytes wait")

  // A stalled receiver freezes the byte count of the back end.
  `MSBBP_CHK_NEXT(a_stall_freezes, back_stat.busy && out_ch.valid && !out_ch.ready, back_stat.left == $past(back_stat.left), "back end advanced under stall")

endmodule

/* rtl/msbbp_front.sv */
`timescale 1ns / 1ps
// Turns each input word into a queue entry: a field to append or a flush.
module msbbp_front (
  msbbp_in_if.sink        in_ch,
  output msbbp_pkg::entry_t entry,
  output logic            push_valid,
  input  logic            push_ready
);

  logic [5:0] nbits_sat;

  assign nbits_sat = (in_ch.field_bits > 6'(msbbp_pkg::FIELD_LIMIT))
                   ? 6'(msbbp_pkg::FIELD_LIMIT) : in_ch.field_bits;

  always_comb begin
    entry.kind  = msbbp_pkg::KIND_APPEND;
    entry.data  = in_ch.data_value;
    entry.nbits = 6'd0;
    unique case (in_ch.cmd)
      msbbp_pkg::CMD_WRITE_BITS: begin
        entry.nbits = nbits_sat;
      end
      msbbp_pkg::CMD_WRITE_WORD: begin
        // Least significant byte goes out first, so it leads the field.
        entry.data  = {in_ch.data_value[7:0], in_ch.data_value[15:8],
                       in_ch.data_value[23:16], in_ch.data_value[31:24]};
        entry.nbits = 6'(msbbp_pkg::FIELD_LIMIT);
      end
      msbbp_pkg::CMD_FLUSH: begin
        entry.kind = msbbp_pkg::KIND_FLUSH;
        entry.data = 32'd0;
      end
      default: begin
        // Unused code: an empty append leaves the state alone.
        entry.nbits = 6'd0;
      end
    endcase
  end

  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;

endmodule

/* rtl/msbbp_queue.sv */
`timescale 1ns / 1ps
// Small first-in first-out queue of decoded operations.
module msbbp_queue #(
  parameter int DEPTH = msbbp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  msbbp_pkg::entry_t push_entry,
  input  logic              push_valid,
  output logic              push_ready,
  output msbbp_pkg::entry_t pop_entry,
  output logic              pop_valid,
  input  logic              pop_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  msbbp_pkg::entry_t mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

/* rtl/msbbp_back.sv */
`timescale 1ns / 1ps
// Holds the pending bits, merges each operation into them and sends the
// completed bytes out one per cycle, unless out_ch stalls, through an output register.
module msbbp_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  msbbp_pkg::entry_t       q_entry,
  input  logic                    q_valid,
  output logic                    q_ready,
  msbbp_out_if.source             out_ch,
  output msbbp_pkg::back_status_t status
);

  function automatic logic [6:0] low_mask(input logic [2:0] k);
    logic [7:0] m;
    m = (8'd1 << k) - 8'd1;
    return m[6:0];
  endfunction

  logic [6:0]  pb_r, pb_nxt;
  logic [2:0]  pc_r, pc_nxt;
  logic [31:0] sr_r, sr_nxt;
  logic [2:0]  left_r, left_nxt;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;

  logic        is_flush;
  logic [5:0]  n_eff;
  logic [31:0] data_eff;
  logic [5:0]  total;
  logic [2:0]  nbytes;
  logic [2:0]  rem;
  logic [31:0] v_al;
  logic [39:0] v_sh;
  logic [6:0]  p_al;
  logic [39:0] stream;
  logic        emit_go;
  logic        pop;

  // A flush appends just enough zeros to finish the pending byte.
  assign is_flush = (q_entry.kind == msbbp_pkg::KIND_FLUSH);
  assign data_eff = is_flush ? 32'd0 : q_entry.data;
  assign n_eff    = !is_flush ? q_entry.nbits
                  : (pc_r == 3'd0) ? 6'd0
                  : 6'(msbbp_pkg::BYTE_BITS) - {3'd0, pc_r};

  assign total  = {3'd0, pc_r} + n_eff;
  assign nbytes = total[5:3];
  assign rem    = total[2:0];

  // Left-align pending bits and field in a 40-bit window.
  assign v_al   = data_eff << (6'd32 - n_eff);
  assign v_sh   = {v_al, 8'd0} >> pc_r;
  assign p_al   = pb_r << (3'd7 - pc_r);
  assign stream = {p_al, 33'd0} | v_sh;

  assign emit_go = (left_r != 3'd0) && (!out_valid_r || out_ch.ready);
  assign q_ready = (left_r == 3'd0) || ((left_r == 3'd1) && emit_go);
  assign pop     = q_valid && q_ready;

  always_comb begin
    pb_nxt   = pb_r;
    pc_nxt   = pc_r;
    sr_nxt   = sr_r;
    left_nxt = left_r;
    if (pop) begin
      sr_nxt   = stream[39:8];
      left_nxt = nbytes;
      pc_nxt   = rem;
      if (nbytes == 3'd0) begin
        pb_nxt = 7'(pb_r << n_eff[2:0]) | (data_eff[6:0] & low_mask(n_eff[2:0]));
      end else begin
        pb_nxt = data_eff[6:0] & low_mask(rem);
      end
    end else if (emit_go) begin
      sr_nxt   = sr_r << 8;
      left_nxt = left_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pb_r        <= '0;
      pc_r        <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pb_r   <= pb_nxt;
      pc_r   <= pc_nxt;
      left_r <= left_nxt;
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sr_r <= sr_nxt;
    if (emit_go) begin
      out_byte_r <= sr_r[31:24];
      out_last_r <= (left_r == 3'd1);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.last_of_run = out_last_r;

  assign status.busy = (left_r != 3'd0);
  assign status.left = left_r;

endmodule
